// File: src/gdda_pkg.sv
// shared constants, register codes and face codes for the grid dda ray caster
// used by gdda_div and grid_dda_ray_caster; depends on nothing
package gdda_pkg;

    // map and screen geometry
    localparam int MAP_DIM      = 64;
    localparam int SCREEN_WIDTH = 1024;
    localparam int TEXTURE_SIZE = 64;
    localparam int MAP_BITS     = $clog2(MAP_DIM);
    localparam int CELL_AW      = 2 * MAP_BITS;
    localparam int CELL_DEPTH   = MAP_DIM * MAP_DIM;
    localparam int CELL_W       = 41;
    localparam int COORD_W      = 8;

    // fixed point widths
    localparam int FRAC_ONE  = 65536;
    localparam int CAM_SCALE = 2 * FRAC_ONE;
    localparam int RAY_W     = 19;
    localparam int STEP_W    = 34;
    localparam int SIDE_W    = 44;
    localparam int ACC_W     = 51;
    localparam int DIST_W    = 24;
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [7:0]        SOLID_KIND = 8'd65;
    localparam logic [DIST_W-1:0] DIST_MAX   = '1;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PLAYER_X   = 3'd0,
        CFG_PLAYER_Y   = 3'd1,
        CFG_VIEW_DIR_X = 3'd2,
        CFG_VIEW_DIR_Y = 3'd3,
        CFG_PLANE_X    = 3'd4,
        CFG_PLANE_Y    = 3'd5,
        CFG_MAP_WIDTH  = 3'd6,
        CFG_MAP_HEIGHT = 3'd7
    } cfg_index_t;

    // face codes
    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_EAST  = 2'd1;
    localparam logic [1:0] FACE_SOUTH = 2'd2;
    localparam logic [1:0] FACE_WEST  = 2'd3;

    // register reset values
    localparam logic [17:0] VIEW_DIR_X_RST = 18'd65536;
    localparam logic [17:0] PLANE_Y_RST    = 18'd43253;
    localparam logic [6:0]  MAP_SIZE_RST   = 7'd64;

endpackage

// File: src/gdda_ram.sv
// generic single write port, single read port ram with registered read data
// depends on nothing
module gdda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/gdda_div.sv
// restoring divider: 2^32 divided by an unsigned ray magnitude, one bit a cycle
// depends on gdda_pkg
module gdda_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gdda_pkg::RAY_W-1:0]  divisor,
    output logic                        done,
    output logic [gdda_pkg::STEP_W-1:0] quotient
);
    import gdda_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [RAY_W-1:0]     rem_reg;
    logic [RAY_W-1:0]     div_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic [RAY_W:0]       trial;
    logic                 fits;

    // next partial remainder, dividend has only its top bit set
    assign trial = {rem_reg, (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))};
    assign fits  = trial >= {1'b0, div_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? RAY_W'(trial - {1'b0, div_reg}) : RAY_W'(trial);
            quo_reg <= {quo_reg[DIV_STEPS-2:0], fits};
        end
    end

    // zero divisor saturates at 2^33
    assign done     = done_reg;
    assign quotient = (div_reg == '0) ? {1'b1, {(STEP_W-1){1'b0}}} : {1'b0, quo_reg};

endmodule

// File: src/grid_dda_ray_caster.sv
// grid dda ray caster top level: map store, ray setup, dda walk, result output
// depends on gdda_pkg, gdda_ram and gdda_div
//
// usage: items arrive on the in channel (in_valid / in_stall), one result per
// item leaves on the out channel (out_valid / out_stall). action 0 writes one
// map cell into the grid ram and returns an all-zero result; action 1 casts a
// ray for screen_column and returns hit flag, face, texture byte minus one,
// texture column, perpendicular distance and hit cell (all zero on a miss).
// one item is worked on at a time; the next is taken as soon as the previous
// result sits in the output register.
// a cast runs the x and y step dividers, then a ram read in each dda step;
// a walk visits at most width plus height minus one cells.
// configuration writes (cfg_valid / cfg_ready, always ready) set the player,
// view and map size; reset restores their defaults. map cells are undefined
// until loaded. a stalled result holds in the output register while the
// next item proceeds; that item waits at the end for the register to free.
module grid_dda_ray_caster (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [7:0]  cell_kind,
    input  logic        cell_is_moving_door,
    input  logic [7:0]  face_north,
    input  logic [7:0]  face_east,
    input  logic [7:0]  face_south,
    input  logic [7:0]  face_west,
    input  logic [9:0]  screen_column,
    input  logic        draw_moving_doors,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        wall_hit,
    output logic [1:0]  face_side,
    output logic [7:0]  texture_id,
    output logic [5:0]  texture_column,
    output logic [23:0] wall_distance,
    output logic [5:0]  hit_cell_x,
    output logic [5:0]  hit_cell_y,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [21:0] cfg_data
);
    import gdda_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_RAYX  = 16'h0002,
        S_RAYY  = 16'h0004,
        S_RAYF  = 16'h0008,
        S_DIVS  = 16'h0010,
        S_DIVW  = 16'h0020,
        S_SXL   = 16'h0040,
        S_SXH   = 16'h0080,
        S_SYL   = 16'h0100,
        S_SYH   = 16'h0200,
        S_SYF   = 16'h0400,
        S_STEP  = 16'h0800,
        S_CHECK = 16'h1000,
        S_TEX   = 16'h2000,
        S_TEXF  = 16'h4000,
        S_FIN   = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [21:0]        player_x_reg, player_y_reg;
    logic signed [17:0] view_dir_x_reg, view_dir_y_reg, plane_x_reg, plane_y_reg;
    logic [6:0]         map_width_reg, map_height_reg;

    // item and datapath registers
    logic [9:0]                col_reg;
    logic                      draw_reg;
    logic signed [RAY_W-1:0]   rx_reg, ry_reg;
    logic [STEP_W-1:0]         dx_reg, dy_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [SIDE_W-1:0]         sx_reg, sy_reg, last_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic                      xside_reg;
    logic [DIST_W-1:0]         dist_reg;
    logic signed [43:0]        prod_reg;

    // result and output registers
    logic              res_hit_reg;
    logic [1:0]        res_face_reg;
    logic [7:0]        res_tex_reg;
    logic [5:0]        res_col_reg;
    logic [5:0]        res_cx_reg, res_cy_reg;
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [1:0]        out_face_reg;
    logic [7:0]        out_tex_reg;
    logic [5:0]        out_col_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic [5:0]        out_cx_reg, out_cy_reg;

    logic               in_xfer, fin_go;
    logic [27:0]        cam_scaled;
    logic signed [17:0] cam;
    logic               rx_neg, ry_neg, rx_pos;
    logic [RAY_W-1:0]   abs_rx, abs_ry;
    logic [16:0]        fsel_x, fsel_y;
    logic signed [24:0] mul_a;
    logic signed [18:0] mul_b;
    logic               div_start, done_x, done_y;
    logic [STEP_W-1:0]  quo_x, quo_y;
    logic [COORD_W-1:0] map_w, map_h;
    logic               take_x;
    logic signed [COORD_W-1:0] nx, ny;
    logic               off_map;
    logic [CELL_AW-1:0] raddr, waddr;
    logic [CELL_W-1:0]  wdata, rdata;
    logic               we;
    logic               solid;
    logic [1:0]         face;
    logic [7:0]         tex_byte;
    logic [15:0]        frac;
    logic [31:0]        tprod;
    logic [15:0]        tcol;

    assign in_xfer   = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign fin_go    = !out_valid_reg || !out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg   <= '0;
            player_y_reg   <= '0;
            view_dir_x_reg <= VIEW_DIR_X_RST;
            view_dir_y_reg <= '0;
            plane_x_reg    <= '0;
            plane_y_reg    <= PLANE_Y_RST;
            map_width_reg  <= MAP_SIZE_RST;
            map_height_reg <= MAP_SIZE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PLAYER_X:   player_x_reg   <= cfg_data;
                CFG_PLAYER_Y:   player_y_reg   <= cfg_data;
                CFG_VIEW_DIR_X: view_dir_x_reg <= cfg_data[17:0];
                CFG_VIEW_DIR_Y: view_dir_y_reg <= cfg_data[17:0];
                CFG_PLANE_X:    plane_x_reg    <= cfg_data[17:0];
                CFG_PLANE_Y:    plane_y_reg    <= cfg_data[17:0];
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_data[6:0];
                CFG_MAP_HEIGHT: map_height_reg <= cfg_data[6:0];
                default:        ;
            endcase
        end
    end

    // camera coordinate for the column
    assign cam_scaled = (28'(col_reg) * 28'(CAM_SCALE)) / 28'(SCREEN_WIDTH);
    assign cam        = signed'(18'(cam_scaled) - 18'(FRAC_ONE));

    // ray signs and magnitudes
    assign rx_neg = rx_reg[RAY_W-1];
    assign ry_neg = ry_reg[RAY_W-1];
    assign rx_pos = !rx_neg && (rx_reg != '0);
    assign abs_rx = rx_neg ? RAY_W'(-rx_reg) : RAY_W'(rx_reg);
    assign abs_ry = ry_neg ? RAY_W'(-ry_reg) : RAY_W'(ry_reg);
    assign fsel_x = rx_neg ? {1'b0, player_x_reg[15:0]}
                           : 17'(FRAC_ONE) - {1'b0, player_x_reg[15:0]};
    assign fsel_y = ry_neg ? {1'b0, player_y_reg[15:0]}
                           : 17'(FRAC_ONE) - {1'b0, player_y_reg[15:0]};

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_RAYX:
            begin
                mul_a = 25'(cam);
                mul_b = 19'(plane_x_reg);
            end
            S_RAYY:
            begin
                mul_a = 25'(cam);
                mul_b = 19'(plane_y_reg);
            end
            S_SXL:
            begin
                mul_a = signed'({8'd0, dx_reg[16:0]});
                mul_b = signed'({2'd0, fsel_x});
            end
            S_SXH:
            begin
                mul_a = signed'({8'd0, dx_reg[33:17]});
                mul_b = signed'({2'd0, fsel_x});
            end
            S_SYL:
            begin
                mul_a = signed'({8'd0, dy_reg[16:0]});
                mul_b = signed'({2'd0, fsel_y});
            end
            S_SYH:
            begin
                mul_a = signed'({8'd0, dy_reg[33:17]});
                mul_b = signed'({2'd0, fsel_y});
            end
            S_TEX:
            begin
                mul_a = signed'({1'b0, dist_reg});
                mul_b = xside_reg ? ry_reg : rx_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // step length dividers
    assign div_start = state_reg == S_DIVS;

    gdda_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (abs_rx),
        .done     (done_x),
        .quotient (quo_x)
    );

    gdda_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (abs_ry),
        .done     (done_y),
        .quotient (quo_y)
    );

    // map bounds and next dda cell
    assign map_w   = (8'(map_width_reg) > 8'(MAP_DIM)) ? 8'(MAP_DIM) : 8'(map_width_reg);
    assign map_h   = (8'(map_height_reg) > 8'(MAP_DIM)) ? 8'(MAP_DIM) : 8'(map_height_reg);
    assign take_x  = sx_reg < sy_reg;
    assign nx      = take_x ? (rx_neg ? cx_reg - 1'b1 : cx_reg + 1'b1) : cx_reg;
    assign ny      = take_x ? cy_reg : (ry_neg ? cy_reg - 1'b1 : cy_reg + 1'b1);
    assign off_map = nx[COORD_W-1] || ($unsigned(nx) >= map_w)
                  || ny[COORD_W-1] || ($unsigned(ny) >= map_h);

    // grid map store
    assign we    = in_xfer && !action && (32'(cell_x) < MAP_DIM) && (32'(cell_y) < MAP_DIM);
    assign waddr = {cell_y[MAP_BITS-1:0], cell_x[MAP_BITS-1:0]};
    assign wdata = {face_west, face_south, face_east, face_north, cell_is_moving_door, cell_kind};
    assign raddr = {ny[MAP_BITS-1:0], nx[MAP_BITS-1:0]};

    gdda_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // hit test and face texture
    assign solid = (rdata[7:0] > SOLID_KIND) && (draw_reg || !rdata[8]);
    assign face  = xside_reg ? (rx_neg ? FACE_WEST : FACE_EAST)
                             : (ry_neg ? FACE_NORTH : FACE_SOUTH);
    always_comb
    begin
        case (face)
            FACE_NORTH: tex_byte = rdata[16:9];
            FACE_EAST:  tex_byte = rdata[24:17];
            FACE_SOUTH: tex_byte = rdata[32:25];
            default:    tex_byte = rdata[40:33];
        endcase
    end

    // texture column from the struck position
    assign frac  = (xside_reg ? player_y_reg[15:0] : player_x_reg[15:0]) + prod_reg[31:16];
    assign tprod = 32'(frac) * 32'(TEXTURE_SIZE);
    assign tcol  = ((xside_reg && rx_pos) || (!xside_reg && ry_neg))
                 ? 16'(TEXTURE_SIZE - 1) - tprod[31:16] : tprod[31:16];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_xfer) state_next = action ? S_RAYX : S_FIN;
            S_RAYX:  state_next = S_RAYY;
            S_RAYY:  state_next = S_RAYF;
            S_RAYF:  state_next = S_DIVS;
            S_DIVS:  state_next = S_DIVW;
            S_DIVW:  if (done_x && done_y) state_next = S_SXL;
            S_SXL:   state_next = S_SXH;
            S_SXH:   state_next = S_SYL;
            S_SYL:   state_next = S_SYH;
            S_SYH:   state_next = S_SYF;
            S_SYF:   state_next = S_STEP;
            S_STEP:  state_next = off_map ? S_FIN : S_CHECK;
            S_CHECK: state_next = solid ? S_TEX : S_STEP;
            S_TEX:   state_next = S_TEXF;
            S_TEXF:  state_next = S_FIN;
            S_FIN:   if (fin_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath updates
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                col_reg      <= screen_column;
                draw_reg     <= draw_moving_doors;
                res_hit_reg  <= 1'b0;
                res_face_reg <= '0;
                res_tex_reg  <= '0;
                res_col_reg  <= '0;
                res_cx_reg   <= '0;
                res_cy_reg   <= '0;
                dist_reg     <= '0;
            end
            S_RAYY: rx_reg <= RAY_W'(44'(view_dir_x_reg) + (prod_reg >>> 16));
            S_RAYF: ry_reg <= RAY_W'(44'(view_dir_y_reg) + (prod_reg >>> 16));
            S_DIVW:
            begin
                dx_reg <= quo_x;
                dy_reg <= quo_y;
            end
            S_SXH:  acc_reg <= ACC_W'(prod_reg[33:0]);
            S_SYL:  sx_reg  <= SIDE_W'((acc_reg + {prod_reg[33:0], 17'd0}) >> 16);
            S_SYH:  acc_reg <= ACC_W'(prod_reg[33:0]);
            S_SYF:
            begin
                sy_reg <= SIDE_W'((acc_reg + {prod_reg[33:0], 17'd0}) >> 16);
                cx_reg <= signed'(COORD_W'(player_x_reg[21:16]));
                cy_reg <= signed'(COORD_W'(player_y_reg[21:16]));
            end
            S_STEP:
            begin
                cx_reg    <= nx;
                cy_reg    <= ny;
                xside_reg <= take_x;
                if (take_x)
                begin
                    last_reg <= sx_reg;
                    sx_reg   <= sx_reg + SIDE_W'(dx_reg);
                end
                else
                begin
                    last_reg <= sy_reg;
                    sy_reg   <= sy_reg + SIDE_W'(dy_reg);
                end
            end
            S_CHECK:
            begin
                if (solid)
                begin
                    dist_reg     <= (last_reg > SIDE_W'(DIST_MAX)) ? DIST_MAX
                                                                   : last_reg[DIST_W-1:0];
                    res_hit_reg  <= 1'b1;
                    res_face_reg <= face;
                    res_tex_reg  <= tex_byte - 8'd1;
                    res_cx_reg   <= cx_reg[5:0];
                    res_cy_reg   <= cy_reg[5:0];
                end
            end
            S_TEXF: res_col_reg <= tcol[5:0];
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_FIN && fin_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && fin_go)
        begin
            out_hit_reg  <= res_hit_reg;
            out_face_reg <= res_face_reg;
            out_tex_reg  <= res_tex_reg;
            out_col_reg  <= res_col_reg;
            out_dist_reg <= dist_reg;
            out_cx_reg   <= res_cx_reg;
            out_cy_reg   <= res_cy_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign wall_hit       = out_hit_reg;
    assign face_side      = out_face_reg;
    assign texture_id     = out_tex_reg;
    assign texture_column = out_col_reg;
    assign wall_distance  = out_dist_reg;
    assign hit_cell_x     = out_cx_reg;
    assign hit_cell_y     = out_cy_reg;

`ifndef SYNTH
    // a reported hit lies inside the map in use
    a_hit_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wall_hit |-> (8'(hit_cell_x) < map_w) && (8'(hit_cell_y) < map_h))
        else $error("hit cell outside map");

    // loads and misses give an all-zero result
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !wall_hit |-> face_side == '0 && texture_id == '0
            && texture_column == '0 && wall_distance == '0
            && hit_cell_x == '0 && hit_cell_y == '0)
        else $error("nonzero fields on a miss");

    // each cell test follows the step that issued its ram read
    a_check_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> $past(state_reg) == S_STEP)
        else $error("cell test without ram read");
`endif

endmodule
